// ===== hw/rtl/bpf_instruction_decoder_top_macros.svh =====
`ifndef BPF_INSTRUCTION_DECODER_TOP_MACROS_SVH
`define BPF_INSTRUCTION_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked on i_clk, off while in reset
`define BPFID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BPFID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bpfid_pkg.sv =====
package bpfid_pkg;

    localparam int unsigned K_W    = 32;
    localparam int unsigned OFFS_W = 8;

    // instruction classes
    localparam logic [2:0] CLS_LD   = 3'd0;
    localparam logic [2:0] CLS_LDX  = 3'd1;
    localparam logic [2:0] CLS_ST   = 3'd2;
    localparam logic [2:0] CLS_STX  = 3'd3;
    localparam logic [2:0] CLS_ALU  = 3'd4;
    localparam logic [2:0] CLS_JMP  = 3'd5;
    localparam logic [2:0] CLS_RET  = 3'd6;
    localparam logic [2:0] CLS_MISC = 3'd7;

    // load modes, code bits 7:5
    localparam logic [2:0] MODE_IMM = 3'd0;
    localparam logic [2:0] MODE_ABS = 3'd1;
    localparam logic [2:0] MODE_MEM = 3'd3;
    localparam logic [2:0] MODE_LEN = 3'd4;

    // ALU op index, code bits 7:4
    localparam logic [3:0] ALU_NEG = 4'h8;
    localparam logic [3:0] ALU_XOR = 4'hA;

    // jump op index, code bits 7:4
    localparam logic [3:0] JOP_JA   = 4'h0;
    localparam logic [3:0] JOP_JEQ  = 4'h1;
    localparam logic [3:0] JOP_JGE  = 4'h3;
    localparam logic [3:0] JOP_JSET = 4'h4;

    // return value source, code bits 4:3
    localparam logic [1:0] RVAL_K = 2'd0;
    localparam logic [1:0] RVAL_A = 2'd2;

    localparam logic [1:0] KIND_ASSIGN = 2'd0;
    localparam logic [1:0] KIND_JUMP   = 2'd1;
    localparam logic [1:0] KIND_RET    = 2'd2;

    localparam logic [1:0] DST_A   = 2'd0;
    localparam logic [1:0] DST_X   = 2'd1;
    localparam logic [1:0] DST_MEM = 2'd2;

    localparam logic [3:0] OP_ASSIGN = 4'd0;
    localparam logic [3:0] OP_XOR    = 4'd10;

    localparam logic [3:0] SRC_A       = 4'd0;
    localparam logic [3:0] SRC_X       = 4'd1;
    localparam logic [3:0] SRC_CONST   = 4'd2;
    localparam logic [3:0] SRC_MEM     = 4'd3;
    localparam logic [3:0] SRC_SYS     = 4'd4;
    localparam logic [3:0] SRC_LOWARG  = 4'd8;
    localparam logic [3:0] SRC_HIGHARG = 4'd9;
    localparam logic [3:0] SRC_LEN     = 4'd10;

    localparam logic [2:0] CMP_EQ  = 3'd0;
    localparam logic [2:0] CMP_SET = 3'd3;
    localparam logic [2:0] CMP_NE  = 3'd4;

    localparam logic [5:0] ARG_BASE = 6'h10;

    typedef struct packed {
        logic [15:0]       code;
        logic [OFFS_W-1:0] jt;
        logic [OFFS_W-1:0] jf;
        logic [K_W-1:0]    k;
    } t_insn;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        dst;
        logic [3:0]        op;
        logic [3:0]        src;
        logic [K_W-1:0]    value;
        logic              cond;
        logic              neg;
        logic [2:0]        cmp;
        logic [K_W-1:0]    jt;
        logic [OFFS_W-1:0] jf;
        logic              inv;
    } t_dec;

endpackage

// ===== hw/rtl/bpf_instruction_decoder_top.sv =====
// Classic seccomp BPF instruction decoder.
// An accepted request passes the input register, then the result register, to o_valid.
// Throughput: one instruction per cycle unless stalled; registers decouple the sides.
// Reset (i_rst_n low, synchronous) empties both stages; payload registers are not reset.
`include "bpf_instruction_decoder_top_macros.svh"

module bpf_instruction_decoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [15:0]                       i_code,
    input  logic [bpfid_pkg::OFFS_W-1:0]      i_true_offset,
    input  logic [bpfid_pkg::OFFS_W-1:0]      i_false_offset,
    input  logic [bpfid_pkg::K_W-1:0]         i_operand_k,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_kind,
    output logic [1:0]                        o_destination,
    output logic [3:0]                        o_operation,
    output logic [3:0]                        o_source_kind,
    output logic [bpfid_pkg::K_W-1:0]         o_value,
    output logic                              o_conditional,
    output logic                              o_negated,
    output logic [2:0]                        o_comparator,
    output logic [bpfid_pkg::K_W-1:0]         o_jump_true,
    output logic [bpfid_pkg::OFFS_W-1:0]      o_jump_false,
    output logic                              o_invalid
);
    import bpfid_pkg::*;

    logic   r_in_valid;
    t_insn  r_in;
    logic   r_out_valid;
    t_dec   r_out;
    t_dec   n_out;

    logic       out_en;
    logic       in_en;
    logic [7:0] c;
    logic [2:0] cls;
    logic [3:0] idx;
    logic [5:0] arg_off;
    logic       swap;

    assign out_en  = !r_out_valid || !i_stall;
    assign in_en   = !r_in_valid || out_en;
    assign o_stall = !in_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_en) begin
            r_in_valid <= i_valid;
        end
        if (in_en && i_valid) begin
            r_in <= '{code: i_code, jt: i_true_offset, jf: i_false_offset, k: i_operand_k};
        end
    end

    assign c       = r_in.code[7:0];
    assign cls     = c[2:0];
    assign idx     = c[7:4];
    assign arg_off = r_in.k[5:0] - ARG_BASE;
    assign swap    = (r_in.jt == '0) && (r_in.jf != '0);

    always_comb begin
        n_out = '0;
        unique case (cls)
            CLS_LD, CLS_LDX: begin
                n_out.kind = KIND_ASSIGN;
                n_out.dst  = (cls == CLS_LD) ? DST_A : DST_X;
                priority if (c[7:5] == MODE_IMM) begin
                    n_out.src   = SRC_CONST;
                    n_out.value = r_in.k;
                end else if (c[7:5] == MODE_MEM) begin
                    n_out.src   = SRC_MEM;
                    n_out.value = r_in.k;
                end else if (c[7:5] == MODE_LEN) begin
                    n_out.src = SRC_LEN;
                end else if (c[7:5] == MODE_ABS) begin
                    // word index k>>2: 0..3 fixed fields, 4..15 argument halves
                    priority if (|r_in.k[K_W-1:6]) begin
                        n_out.inv = 1'b1;
                    end else if (r_in.k[5:4] == 2'd0) begin
                        n_out.src = SRC_SYS + {2'b00, r_in.k[3:2]};
                    end else begin
                        n_out.src   = r_in.k[2] ? SRC_HIGHARG : SRC_LOWARG;
                        n_out.value = {{(K_W-3){1'b0}}, arg_off[5:3]};
                    end
                end else begin
                    n_out.inv = 1'b1;
                end
            end
            CLS_ST, CLS_STX: begin
                n_out.kind  = KIND_ASSIGN;
                n_out.dst   = DST_MEM;
                n_out.src   = (cls == CLS_ST) ? SRC_A : SRC_X;
                n_out.value = r_in.k;
            end
            CLS_ALU: begin
                n_out.kind = KIND_ASSIGN;
                n_out.dst  = DST_A;
                priority if (idx <= ALU_NEG) begin
                    n_out.op = idx + 4'd1;
                end else if (idx == ALU_XOR) begin
                    n_out.op = OP_XOR;
                end else begin
                    n_out.op  = OP_ASSIGN;
                    n_out.inv = 1'b1;
                end
                priority if (c[3]) begin
                    n_out.src = SRC_X;
                end else if (idx == ALU_NEG) begin
                    n_out.src = SRC_A;
                end else begin
                    n_out.src   = SRC_CONST;
                    n_out.value = r_in.k;
                end
            end
            CLS_JMP: begin
                n_out.kind = KIND_JUMP;
                if (idx == JOP_JA) begin
                    n_out.jt = r_in.k;
                end else begin
                    n_out.cond = 1'b1;
                    n_out.jt   = {{(K_W-OFFS_W){1'b0}}, swap ? r_in.jf : r_in.jt};
                    n_out.jf   = swap ? r_in.jt : r_in.jf;
                    priority if (idx == JOP_JSET) begin
                        n_out.cmp = CMP_SET;
                        n_out.neg = swap;
                    end else if (idx <= JOP_JGE) begin
                        // swapped offsets take the reverse comparator
                        n_out.cmp = swap ? (idx[2:0] + CMP_SET)
                                         : (idx[2:0] - JOP_JEQ[2:0]);
                    end else begin
                        n_out.cmp = CMP_EQ;
                        n_out.inv = 1'b1;
                    end
                    if (c[3]) begin
                        n_out.src = SRC_X;
                    end else begin
                        n_out.src   = SRC_CONST;
                        n_out.value = r_in.k;
                    end
                end
            end
            CLS_RET: begin
                n_out.kind = KIND_RET;
                priority if (c[4:3] == RVAL_K) begin
                    n_out.src   = SRC_CONST;
                    n_out.value = r_in.k;
                end else if (c[4:3] == RVAL_A) begin
                    n_out.src = SRC_A;
                end else begin
                    n_out.inv = 1'b1;
                end
            end
            CLS_MISC: begin
                // TAX when the upper bits are clear, TXA otherwise
                n_out.kind = KIND_ASSIGN;
                if (c[7:3] == 5'd0) begin
                    n_out.dst = DST_X;
                    n_out.src = SRC_A;
                end else begin
                    n_out.dst = DST_A;
                    n_out.src = SRC_X;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_in_valid;
        end
        if (out_en && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_destination = r_out.dst;
    assign o_operation   = r_out.op;
    assign o_source_kind = r_out.src;
    assign o_value       = r_out.value;
    assign o_conditional = r_out.cond;
    assign o_negated     = r_out.neg;
    assign o_comparator  = r_out.cmp;
    assign o_jump_true   = r_out.jt;
    assign o_jump_false  = r_out.jf;
    assign o_invalid     = r_out.inv;

    `BPFID_ASSERT_NOW(a_stall_full, o_stall, r_in_valid && r_out_valid, "stall with a free stage")
    `BPFID_ASSERT_NEXT(a_accept_lands, i_valid && !o_stall, r_in_valid, "accepted request lost")
    `BPFID_ASSERT_NOW(a_nonjump_clear, o_valid && o_kind != KIND_JUMP, !o_conditional && o_jump_true == '0 && o_jump_false == '0, "jump fields set on non-jump")
    `BPFID_ASSERT_NOW(a_neg_jset, o_valid && o_negated, o_conditional && o_comparator == CMP_SET, "negate outside bit test")

endmodule

// ===== verif/tb_bpf_instruction_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_bpf_instruction_decoder_top;
    import bpfid_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 750;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned MAX_REPORTS     = 10;

    // codes the package leaves out
    localparam logic [2:0] MODE_IND  = 3'd2;
    localparam logic [1:0] SZ_W      = 2'd0;
    localparam logic [3:0] ALU_ADD   = 4'h0;
    localparam logic [3:0] ALU_MOD   = 4'h9;
    localparam logic [3:0] JOP_JGT   = 4'h2;
    localparam logic [3:0] JOP_BAD   = 4'hF;
    localparam logic [1:0] RVAL_X    = 2'd1;
    localparam logic [1:0] RVAL_RSV  = 2'd3;
    localparam logic       SRCB_K    = 1'b0;
    localparam logic       SRCB_X    = 1'b1;
    localparam logic [4:0] MISC_TAX  = 5'h00;
    localparam logic [4:0] MISC_TXA  = 5'h10;
    localparam int unsigned DATA_WORDS = 16;
    localparam logic [K_W-1:0] ARG_STRIDE = 8;

    typedef struct {
        t_insn insn;
        bit    typed;
        t_dec  rec;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [15:0]         i_code;
    logic [OFFS_W-1:0]   i_true_offset;
    logic [OFFS_W-1:0]   i_false_offset;
    logic [K_W-1:0]      i_operand_k;
    logic                o_valid;
    logic                i_stall;
    logic [1:0]          o_kind;
    logic [1:0]          o_destination;
    logic [3:0]          o_operation;
    logic [3:0]          o_source_kind;
    logic [K_W-1:0]      o_value;
    logic                o_conditional;
    logic                o_negated;
    logic [2:0]          o_comparator;
    logic [K_W-1:0]      o_jump_true;
    logic [OFFS_W-1:0]   o_jump_false;
    logic                o_invalid;

    t_stim_row   directed_rows[$];
    t_dec        pending_decodes[$];
    t_dec        offered_record;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned requests_taken;
    int unsigned records_seen;
    int unsigned jumps_seen;
    int unsigned returns_seen;
    int unsigned invalid_seen;
    int unsigned mismatch_count;

    bpf_instruction_decoder_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_code         (i_code),
        .i_true_offset  (i_true_offset),
        .i_false_offset (i_false_offset),
        .i_operand_k    (i_operand_k),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_destination  (o_destination),
        .o_operation    (o_operation),
        .o_source_kind  (o_source_kind),
        .o_value        (o_value),
        .o_conditional  (o_conditional),
        .o_negated      (o_negated),
        .o_comparator   (o_comparator),
        .o_jump_true    (o_jump_true),
        .o_jump_false   (o_jump_false),
        .o_invalid      (o_invalid)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // expected decode of one instruction; only code bits 7:0 matter
    function automatic t_dec decode_insn(t_insn r);
        logic [7:0]  c;
        logic [3:0]  idx;
        logic [29:0] word;
        logic        swap;
        t_dec        d;
        d    = '0;
        c    = r.code[7:0];
        idx  = c[7:4];
        word = r.k[K_W-1:2];
        case (c[2:0])
            CLS_LD, CLS_LDX: begin
                d.kind = KIND_ASSIGN;
                d.dst  = (c[2:0] == CLS_LD) ? DST_A : DST_X;
                case (c[7:5])
                    MODE_IMM: begin
                        d.src   = SRC_CONST;
                        d.value = r.k;
                    end
                    MODE_MEM: begin
                        d.src   = SRC_MEM;
                        d.value = r.k;
                    end
                    MODE_LEN: d.src = SRC_LEN;
                    MODE_ABS: begin
                        if (word >= DATA_WORDS) begin
                            d.inv = 1'b1;
                        end else if (word < 4) begin
                            // syscall, arch, low pc, high pc in word order
                            d.src = SRC_SYS + 4'(word[1:0]);
                        end else begin
                            d.src   = word[0] ? SRC_HIGHARG : SRC_LOWARG;
                            d.value = (r.k - ARG_BASE) / ARG_STRIDE;
                        end
                    end
                    default: d.inv = 1'b1;
                endcase
            end
            CLS_ST, CLS_STX: begin
                d.kind  = KIND_ASSIGN;
                d.dst   = DST_MEM;
                d.src   = (c[2:0] == CLS_ST) ? SRC_A : SRC_X;
                d.value = r.k;
            end
            CLS_ALU: begin
                d.kind = KIND_ASSIGN;
                // operator codes run one above the op index up to neg
                if (idx <= ALU_NEG)
                    d.op = idx + 4'd1;
                else if (idx == ALU_XOR)
                    d.op = OP_XOR;
                else
                    d.inv = 1'b1;
                if (c[3] == SRCB_X) begin
                    d.src = SRC_X;
                end else if (idx == ALU_NEG) begin
                    d.src = SRC_A;
                end else begin
                    d.src   = SRC_CONST;
                    d.value = r.k;
                end
            end
            CLS_JMP: begin
                d.kind = KIND_JUMP;
                if (idx == JOP_JA) begin
                    d.jt = r.k;
                end else begin
                    d.cond = 1'b1;
                    swap   = (r.jt == '0) && (r.jf != '0);
                    d.jt   = K_W'(swap ? r.jf : r.jt);
                    d.jf   = swap ? r.jt : r.jf;
                    if (idx == JOP_JSET) begin
                        d.cmp = CMP_SET;
                        d.neg = swap;
                    end else if (idx >= JOP_JEQ && idx <= JOP_JGE) begin
                        d.cmp = (swap ? CMP_NE : CMP_EQ) + 3'(idx - JOP_JEQ);
                    end else begin
                        d.cmp = CMP_EQ;
                        d.inv = 1'b1;
                    end
                    if (c[3] == SRCB_X) begin
                        d.src = SRC_X;
                    end else begin
                        d.src   = SRC_CONST;
                        d.value = r.k;
                    end
                end
            end
            CLS_RET: begin
                d.kind = KIND_RET;
                case (c[4:3])
                    RVAL_K: begin
                        d.src   = SRC_CONST;
                        d.value = r.k;
                    end
                    RVAL_A: d.src = SRC_A;
                    default: d.inv = 1'b1;
                endcase
            end
            default: begin
                if (c[7:3] == MISC_TAX) begin
                    d.dst = DST_X;
                    d.src = SRC_A;
                end else begin
                    d.dst = DST_A;
                    d.src = SRC_X;
                end
            end
        endcase
        return d;
    endfunction

    function automatic logic [15:0] ld_code(logic [2:0] mode, logic [2:0] cls);
        return {8'h00, mode, SZ_W, cls};
    endfunction

    function automatic logic [15:0] op_code(logic [3:0] idx, logic srcb, logic [2:0] cls);
        return {8'h00, idx, srcb, cls};
    endfunction

    function automatic void add_row(logic [15:0] code, logic [7:0] jt, logic [7:0] jf,
                                    logic [31:0] k, bit typed = 1'b0, t_dec rec = '0);
        t_stim_row row;
        row.insn  = '{code: code, jt: jt, jf: jf, k: k};
        row.typed = typed;
        row.rec   = rec;
        directed_rows.push_back(row);
    endfunction

    // mostly well-formed instructions, the rest raw noise
    function automatic t_insn random_insn();
        t_insn r;
        r.code = 16'($urandom);
        r.jt   = 8'($urandom);
        r.jf   = 8'($urandom);
        r.k    = $urandom;
        if ($urandom_range(0, 3) == 0)
            r.k = $urandom_range(0, 255);
        case (r.code[2:0])
            CLS_LD, CLS_LDX: begin
                case ($urandom_range(0, 5))
                    0: r.code[7:5] = MODE_IMM;
                    1, 2: begin
                        r.code[7:5] = MODE_ABS;
                        if ($urandom_range(0, 4) != 0)
                            r.k = $urandom_range(0, 4 * DATA_WORDS + 7);
                    end
                    3: r.code[7:5] = MODE_MEM;
                    4: r.code[7:5] = MODE_LEN;
                    default: ;
                endcase
            end
            CLS_ALU: begin
                if ($urandom_range(0, 3) != 0)
                    r.code[7:4] = 4'($urandom_range(ALU_ADD, ALU_XOR));
            end
            CLS_JMP: begin
                if ($urandom_range(0, 3) != 0)
                    r.code[7:4] = 4'($urandom_range(JOP_JA, JOP_JSET));
                case ($urandom_range(0, 5))
                    0, 1: r.jt = '0;
                    2: r.jf = '0;
                    3: begin
                        r.jt = '0;
                        r.jf = '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic offer_request(input t_insn r, input t_dec rec);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_code         <= r.code;
        i_true_offset  <= r.jt;
        i_false_offset <= r.jf;
        i_operand_k    <= r.k;
        offered_record = rec;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on record %0d: %s expected %0h got %0h",
                     records_seen, field, want, got);
    endtask

    initial begin : stimulus
        int unsigned n;
        t_insn       r;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_code         = '0;
        i_true_offset  = '0;
        i_false_offset = '0;
        i_operand_k    = '0;
        offered_record = '0;
        burst_left     = 0;

        add_row(ld_code(MODE_IMM, CLS_LD), 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1,
                t_dec'{kind: KIND_ASSIGN, dst: DST_A, src: SRC_CONST,
                       value: 32'hFFFF_FFFF, default: '0});
        // upper code byte carries no meaning
        add_row({8'hFF, MODE_IMM, SZ_W, CLS_LDX}, 8'hFF, 8'hFF, 32'h0, 1'b1,
                t_dec'{kind: KIND_ASSIGN, dst: DST_X, src: SRC_CONST, default: '0});
        add_row(ld_code(MODE_ABS, CLS_LDX), 8'h00, 8'h00, 32'h0, 1'b1,
                t_dec'{kind: KIND_ASSIGN, dst: DST_X, src: SRC_SYS, default: '0});
        add_row(ld_code(MODE_ABS, CLS_LD), 8'h00, 8'h00, 32'h7);
        add_row(ld_code(MODE_ABS, CLS_LDX), 8'h00, 8'h00, 32'hF);
        add_row(ld_code(MODE_ABS, CLS_LD), 8'h00, 8'h00, 32'h10);
        add_row(ld_code(MODE_ABS, CLS_LD), 8'h00, 8'h00, 32'h3F);
        add_row(ld_code(MODE_ABS, CLS_LD), 8'h00, 8'h00, 32'h40, 1'b1,
                t_dec'{kind: KIND_ASSIGN, dst: DST_A, inv: 1'b1, default: '0});
        add_row(ld_code(MODE_ABS, CLS_LDX), 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1,
                t_dec'{kind: KIND_ASSIGN, dst: DST_X, inv: 1'b1, default: '0});
        add_row(ld_code(MODE_MEM, CLS_LD), 8'h00, 8'h00, 32'hF);
        add_row(ld_code(MODE_LEN, CLS_LDX), 8'h00, 8'h00, 32'h1234_5678);
        add_row(ld_code(MODE_IND, CLS_LD), 8'h00, 8'h00, 32'h4, 1'b1,
                t_dec'{kind: KIND_ASSIGN, dst: DST_A, inv: 1'b1, default: '0});
        // store ignores the mode bits
        add_row(ld_code(MODE_IND, CLS_ST), 8'h00, 8'h00, 32'hFFFF_FFFF);
        add_row({8'h00, 5'h1F, CLS_STX}, 8'h00, 8'h00, 32'h0);
        add_row(op_code(ALU_ADD, SRCB_K, CLS_ALU), 8'h00, 8'h00, 32'hFFFF_FFFF);
        add_row(op_code(ALU_NEG, SRCB_K, CLS_ALU), 8'h00, 8'h00, 32'hDEAD_BEEF);
        add_row(op_code(ALU_XOR, SRCB_X, CLS_ALU), 8'h00, 8'h00, 32'h5);
        add_row(op_code(ALU_MOD, SRCB_K, CLS_ALU), 8'h00, 8'h00, 32'h1234, 1'b1,
                t_dec'{kind: KIND_ASSIGN, src: SRC_CONST, value: 32'h1234,
                       inv: 1'b1, default: '0});
        add_row(op_code(JOP_JA, SRCB_X, CLS_JMP), 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                t_dec'{kind: KIND_JUMP, jt: 32'hFFFF_FFFF, default: '0});
        add_row(op_code(JOP_JEQ, SRCB_K, CLS_JMP), 8'h00, 8'hFF, 32'h0);
        add_row(op_code(JOP_JGT, SRCB_X, CLS_JMP), 8'hFF, 8'h00, 32'h1);
        add_row(op_code(JOP_JGE, SRCB_K, CLS_JMP), 8'h00, 8'h01, 32'h8000_0000);
        add_row(op_code(JOP_JSET, SRCB_X, CLS_JMP), 8'h00, 8'h09, 32'h0);
        add_row(op_code(JOP_JSET, SRCB_K, CLS_JMP), 8'h00, 8'h00, 32'h2);
        add_row(op_code(JOP_BAD, SRCB_K, CLS_JMP), 8'h00, 8'h03, 32'h7);
        add_row({8'h00, 3'b000, RVAL_K, CLS_RET}, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1,
                t_dec'{kind: KIND_RET, src: SRC_CONST, value: 32'hFFFF_FFFF,
                       default: '0});
        add_row({8'h00, 3'b000, RVAL_A, CLS_RET}, 8'h00, 8'h00, 32'h1);
        add_row({8'h00, 3'b000, RVAL_X, CLS_RET}, 8'h00, 8'h00, 32'h1, 1'b1,
                t_dec'{kind: KIND_RET, inv: 1'b1, default: '0});
        add_row({8'h00, 3'b000, RVAL_RSV, CLS_RET}, 8'h00, 8'h00, 32'h1, 1'b1,
                t_dec'{kind: KIND_RET, inv: 1'b1, default: '0});
        add_row({8'h00, MISC_TAX, CLS_MISC}, 8'h00, 8'h00, 32'h0);
        add_row({8'h00, MISC_TXA, CLS_MISC}, 8'h00, 8'h00, 32'h0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].insn,
                          directed_rows[i].typed ? directed_rows[i].rec
                                                 : decode_insn(directed_rows[i].insn));
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            r = random_insn();
            offer_request(r, decode_insn(r));
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_decodes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Decoded %0d requests (%0d directed, %0d random) with a %0d-cycle hold-off",
                 requests_taken, directed_rows.size(), RANDOM_ITEMS, HOLD_OFF_CYCLES);
        $display("Records: %0d jumps, %0d returns, %0d flagged invalid, %0d mismatches",
                 jumps_seen, returns_seen, invalid_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stall patterns, plus one long hold-off to back up the pipe
    initial begin : result_stall
        int unsigned mode;
        int unsigned span;
        int unsigned held;
        bit          held_off;
        i_stall  = 1'b0;
        held_off = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held_off && records_seen >= 200) begin
                held_off = 1'b1;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_dec want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pending_decodes.push_back(offered_record);
                requests_taken++;
            end
            if (o_valid && !i_stall) begin
                records_seen++;
                if (o_kind == KIND_JUMP)
                    jumps_seen++;
                if (o_kind == KIND_RET)
                    returns_seen++;
                if (o_invalid)
                    invalid_seen++;
                if (pending_decodes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected record %0d: expected none got kind %0h value %0h",
                                 records_seen, o_kind, o_value);
                end else begin
                    want = pending_decodes.pop_front();
                    if (o_kind !== want.kind)
                        note_mismatch("kind", 32'(want.kind), 32'(o_kind));
                    if (o_destination !== want.dst)
                        note_mismatch("destination", 32'(want.dst), 32'(o_destination));
                    if (o_operation !== want.op)
                        note_mismatch("operation", 32'(want.op), 32'(o_operation));
                    if (o_source_kind !== want.src)
                        note_mismatch("source_kind", 32'(want.src), 32'(o_source_kind));
                    if (o_value !== want.value)
                        note_mismatch("value", want.value, o_value);
                    if (o_conditional !== want.cond)
                        note_mismatch("conditional", 32'(want.cond), 32'(o_conditional));
                    if (o_negated !== want.neg)
                        note_mismatch("negated", 32'(want.neg), 32'(o_negated));
                    if (o_comparator !== want.cmp)
                        note_mismatch("comparator", 32'(want.cmp), 32'(o_comparator));
                    if (o_jump_true !== want.jt)
                        note_mismatch("jump_true", want.jt, o_jump_true);
                    if (o_jump_false !== want.jf)
                        note_mismatch("jump_false", 32'(want.jf), 32'(o_jump_false));
                    if (o_invalid !== want.inv)
                        note_mismatch("invalid", 32'(want.inv), 32'(o_invalid));
                end
            end
        end
    end

endmodule
